// ===== rtl/ifx_pkg.sv =====
// ----------------------------------------------------------------------------
// ifx_pkg
// Shared types, codes and lookup functions for the ITCH field extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package ifx_pkg;

	// Result kind codes
	localparam logic [2:0] KIND_ADD  = 3'd0;
	localparam logic [2:0] KIND_EXEC = 3'd1;
	localparam logic [2:0] KIND_DEL  = 3'd2;
	localparam logic [2:0] KIND_EOS  = 3'd3;
	localparam logic [2:0] KIND_BAD  = 3'd4;

	// Type bytes that carry assembled bodies
	localparam logic [7:0] CH_ADD  = 8'h41; // 'A'
	localparam logic [7:0] CH_EXEC = 8'h45; // 'E'
	localparam logic [7:0] CH_DEL  = 8'h44; // 'D'

	// Body lengths, type byte excluded
	localparam logic [5:0] LEN_ADD  = 6'd35;
	localparam logic [5:0] LEN_EXEC = 6'd30;
	localparam logic [5:0] LEN_DEL  = 6'd18;

	// Parser phase
	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_BODY = 2'd1,
		PH_SKIP = 2'd2,
		PH_STOP = 2'd3
	} phase_t;

	// One result beat
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] locate_code;
		logic [15:0] track_num;
		logic [47:0] event_time;
		logic [63:0] order_reference;
		logic [7:0]  side_char;
		logic [31:0] share_count;
		logic [63:0] symbol;
		logic [31:0] price;
		logic [63:0] match_id;
		logic [7:0]  bad_type;
		logic        last_of_run;
	} result_t;

	// Push request from parser to result queue
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// Total length of a skipped message type; zero for an unknown type
	function automatic logic [5:0] skip_size(input logic [7:0] t);
		logic [5:0] s;
		case (t)
			8'h53: s = 6'd12; // S
			8'h52: s = 6'd39; // R
			8'h48: s = 6'd25; // H
			8'h59: s = 6'd20; // Y
			8'h4C: s = 6'd26; // L
			8'h56: s = 6'd35; // V
			8'h57: s = 6'd12; // W
			8'h4B: s = 6'd28; // K
			8'h4A: s = 6'd35; // J
			8'h68: s = 6'd21; // h
			8'h46: s = 6'd40; // F
			8'h43: s = 6'd36; // C
			8'h58: s = 6'd23; // X
			8'h55: s = 6'd35; // U
			8'h50: s = 6'd44; // P
			8'h51: s = 6'd40; // Q
			8'h42: s = 6'd19; // B
			8'h49: s = 6'd50; // I
			8'h4E: s = 6'd20; // N
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	// Body length of an assembled kind
	function automatic logic [5:0] body_len(input logic [1:0] k);
		logic [5:0] l;
		case (k)
			KIND_ADD[1:0]:  l = LEN_ADD;
			KIND_EXEC[1:0]: l = LEN_EXEC;
			default:        l = LEN_DEL;
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ifx_parser.sv =====
// ----------------------------------------------------------------------------
// ifx_parser
// Byte-at-a-time message framer and big-endian field assembler. Produces up
// to two results per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ifx_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      data_byte,
	input  wire logic            is_last,
	output ifx_pkg::push_t       push,
	output ifx_pkg::result_t     res_a,
	output ifx_pkg::result_t     res_b
);

	ifx_pkg::phase_t phase_q, phase_d;
	logic [5:0]  cnt_q, cnt_d, cnt_inc, skip_len;
	logic [1:0]  kind_q, kind_d;

	// Field registers (payload, no reset)
	logic [15:0] locate_q, locate_d;
	logic [15:0] tracking_q, tracking_d;
	logic [47:0] time_q, time_d;
	logic [63:0] ref_q, ref_d;
	logic [7:0]  side_q, side_d;
	logic [31:0] shares_q, shares_d;
	logic [63:0] symbol_q, symbol_d;
	logic [31:0] price_q, price_d;
	logic [63:0] match_q, match_d;

	logic msg_done, bad, eos;
	ifx_pkg::result_t msg_res, bad_res, eos_res;

	assign cnt_inc  = cnt_q + 6'd1;
	assign skip_len = ifx_pkg::skip_size(data_byte);

	// Next state and field assembly
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		kind_d     = kind_q;
		locate_d   = locate_q;
		tracking_d = tracking_q;
		time_d     = time_q;
		ref_d      = ref_q;
		side_d     = side_q;
		shares_d   = shares_q;
		symbol_d   = symbol_q;
		price_d    = price_q;
		match_d    = match_q;
		msg_done   = 1'b0;
		bad        = 1'b0;
		case (phase_q)
			ifx_pkg::PH_TYPE: begin
				if (data_byte == ifx_pkg::CH_ADD || data_byte == ifx_pkg::CH_EXEC ||
				    data_byte == ifx_pkg::CH_DEL) begin
					if (data_byte == ifx_pkg::CH_ADD)
						kind_d = ifx_pkg::KIND_ADD[1:0];
					else if (data_byte == ifx_pkg::CH_EXEC)
						kind_d = ifx_pkg::KIND_EXEC[1:0];
					else
						kind_d = ifx_pkg::KIND_DEL[1:0];
					phase_d = ifx_pkg::PH_BODY;
					cnt_d   = '0;
				end else if (skip_len == '0) begin
					bad     = 1'b1;
					phase_d = ifx_pkg::PH_STOP;
					cnt_d   = '0;
				end else begin
					phase_d = ifx_pkg::PH_SKIP;
					cnt_d   = skip_len - 6'd1;
				end
			end
			ifx_pkg::PH_BODY: begin
				// shift the byte into the field its offset belongs to
				if (cnt_q < 6'd2)
					locate_d = {locate_q[7:0], data_byte};
				else if (cnt_q < 6'd4)
					tracking_d = {tracking_q[7:0], data_byte};
				else if (cnt_q < 6'd10)
					time_d = {time_q[39:0], data_byte};
				else if (cnt_q < 6'd18)
					ref_d = {ref_q[55:0], data_byte};
				else if (kind_q == ifx_pkg::KIND_ADD[1:0]) begin
					if (cnt_q < 6'd19)
						side_d = data_byte;
					else if (cnt_q < 6'd23)
						shares_d = {shares_q[23:0], data_byte};
					else if (cnt_q < 6'd31)
						symbol_d = {symbol_q[55:0], data_byte};
					else
						price_d = {price_q[23:0], data_byte};
				end else if (kind_q == ifx_pkg::KIND_EXEC[1:0]) begin
					if (cnt_q < 6'd22)
						shares_d = {shares_q[23:0], data_byte};
					else
						match_d = {match_q[55:0], data_byte};
				end
				cnt_d = cnt_inc;
				if (cnt_inc >= ifx_pkg::body_len(kind_q)) begin
					msg_done = 1'b1;
					phase_d  = ifx_pkg::PH_TYPE;
					cnt_d    = '0;
				end
			end
			ifx_pkg::PH_SKIP: begin
				if (cnt_q != '0)
					cnt_d = cnt_q - 6'd1;
				if (cnt_q <= 6'd1)
					phase_d = ifx_pkg::PH_TYPE;
			end
			default: ;
		endcase

		// end of stream restarts framing; the stopped state ignores it
		eos = is_last && (phase_q != ifx_pkg::PH_STOP) && !bad;
		if (eos) begin
			phase_d = ifx_pkg::PH_TYPE;
			cnt_d   = '0;
		end
	end

	// Result build
	always_comb begin
		msg_res                 = '0;
		msg_res.kind            = {1'b0, kind_d};
		msg_res.locate_code     = locate_d;
		msg_res.track_num       = tracking_d;
		msg_res.event_time      = time_d;
		msg_res.order_reference = ref_d;
		if (kind_d == ifx_pkg::KIND_ADD[1:0]) begin
			msg_res.side_char   = side_d;
			msg_res.share_count = shares_d;
			msg_res.symbol      = symbol_d;
			msg_res.price       = price_d;
		end else if (kind_d == ifx_pkg::KIND_EXEC[1:0]) begin
			msg_res.share_count = shares_d;
			msg_res.match_id    = match_d;
		end
		msg_res.last_of_run = !eos;

		bad_res             = '0;
		bad_res.kind        = ifx_pkg::KIND_BAD;
		bad_res.bad_type    = data_byte;
		bad_res.last_of_run = 1'b1;

		eos_res             = '0;
		eos_res.kind        = ifx_pkg::KIND_EOS;
		eos_res.last_of_run = 1'b1;

		if (msg_done)
			res_a = msg_res;
		else if (bad)
			res_a = bad_res;
		else
			res_a = eos_res;
		res_b = eos_res;

		push.first  = take && (msg_done || bad || eos);
		push.second = take && msg_done && eos;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ifx_pkg::PH_TYPE;
			cnt_q   <= '0;
			kind_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			kind_q  <= kind_d;
		end
	end

	// Field registers
	always_ff @(posedge clk) begin
		if (take) begin
			locate_q   <= locate_d;
			tracking_q <= tracking_d;
			time_q     <= time_d;
			ref_q      <= ref_d;
			side_q     <= side_d;
			shares_q   <= shares_d;
			symbol_q   <= symbol_d;
			price_q    <= price_d;
			match_q    <= match_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ifx_result_queue.sv =====
// ----------------------------------------------------------------------------
// ifx_result_queue
// Small result queue: takes up to two results a cycle, presents one beat a
// cycle on the output channel, advancing only when the head is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module ifx_result_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ifx_pkg::push_t   push,
	input  wire ifx_pkg::result_t res_a,
	input  wire ifx_pkg::result_t res_b,
	input  wire logic             pop,
	output logic                  has_room,
	output logic                  not_empty,
	output ifx_pkg::result_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ifx_pkg::result_t entry_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_next, wr_next2, rd_next;
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_push;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_next   = ptr_inc(wr_q);
	assign wr_next2  = ptr_inc(wr_next);
	assign rd_next   = ptr_inc(rd_q);
	assign n_push    = CW'(push.first) + CW'(push.second);
	assign has_room  = count_q <= CW'(DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.second)
				wr_q <= wr_next2;
			else if (push.first)
				wr_q <= wr_next;
			if (pop)
				rd_q <= rd_next;
			count_q <= count_q + n_push - CW'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (push.first && wr_q == PW'(i))
				entry_q[i] <= res_a;
			else if (push.second && wr_next == PW'(i))
				entry_q[i] <= res_b;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/itch_message_field_extractor_core.sv =====
// The parser writes each result into the result queue on its byte's beat,
// and the output ports show the queue head. Throughput: one byte per cycle
// while in_ready is high; a byte that ends both a message and the stream
// yields two result beats in order. in_ready falls while the result queue
// has fewer than two free entries. Reset clears framing state and the queue;
// field registers are undefined until a message body writes them.
// ----------------------------------------------------------------------------
// itch_message_field_extractor_core
// ITCH 5.0 stream parser: frames messages, assembles Add, Executed and Delete
// fields, skips other known types and stops on an unknown type byte.
// ----------------------------------------------------------------------------
`default_nettype none

module itch_message_field_extractor_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [15:0]      locate_code,
	output logic [15:0]      track_num,
	output logic [47:0]      event_time,
	output logic [63:0]      order_reference,
	output logic [7:0]       side_char,
	output logic [31:0]      share_count,
	output logic [63:0]      symbol,
	output logic [31:0]      price,
	output logic [63:0]      match_id,
	output logic [7:0]       bad_type,
	output logic             last_of_run
);

	ifx_pkg::push_t   push;
	ifx_pkg::result_t res_a, res_b, head;
	logic take, has_room, pop;

	assign in_ready = has_room;
	assign take     = in_valid && has_room;
	assign pop      = out_valid && out_ready;

	// Framing and field assembly
	ifx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.is_last   (is_last),
		.push      (push),
		.res_a     (res_a),
		.res_b     (res_b)
	);

	// Output buffering
	ifx_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_a     (res_a),
		.res_b     (res_b),
		.pop       (pop),
		.has_room  (has_room),
		.not_empty (out_valid),
		.head      (head)
	);

	assign kind            = head.kind;
	assign locate_code     = head.locate_code;
	assign track_num       = head.track_num;
	assign event_time      = head.event_time;
	assign order_reference = head.order_reference;
	assign side_char       = head.side_char;
	assign share_count     = head.share_count;
	assign symbol          = head.symbol;
	assign price           = head.price;
	assign match_id        = head.match_id;
	assign bad_type        = head.bad_type;
	assign last_of_run     = head.last_of_run;

	// A second result is only ever an end-of-stream after a message
	a_second_is_eos: assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> (push.first && res_b.kind == ifx_pkg::KIND_EOS &&
		                 !res_a.last_of_run))
		else $error("second result not an end-of-stream after a message");

	// Nothing is produced without an accepted beat
	a_push_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		push.first |-> take)
		else $error("result pushed without accepted beat");

	// After an unknown type the parser stays silent
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(push.first && res_a.kind == ifx_pkg::KIND_BAD) |=> !push.first)
		else $error("result produced after unknown type stop");

	// An unknown type result is always alone and final
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(push.first && res_a.kind == ifx_pkg::KIND_BAD) |->
		(!push.second && res_a.last_of_run))
		else $error("unknown type result not alone");

endmodule

`default_nettype wire
